@@ hdl/ipq_pkg.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ipq_pkg
// Types, codes and the ordering function shared by the indexed priority queue.
// -----------------------------------------------------------------------------
package ipq_pkg;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_CANCEL = 2'd1;
   localparam logic [1:0] MODE_TAKE   = 2'd2;

   localparam logic [1:0] ST_DONE = 2'd0;
   localparam logic [1:0] ST_NONE = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam int ID_W     = 15;
   localparam int PROFIT_W = 32;
   localparam int ELEM_W   = ID_W + PROFIT_W;

   typedef struct packed {
      logic [1:0]                 mode;
      logic [ID_W-1:0]            item_id;
      logic signed [PROFIT_W-1:0] profit;
   } req_type;

   typedef struct packed {
      logic [1:0]      status;
      logic [ID_W-1:0] result_id;
   } rsp_type;

   typedef struct packed {
      logic [ID_W-1:0]            id;
      logic signed [PROFIT_W-1:0] profit;
   } elem_type;

   // Larger profit wins; equal profits go to the smaller id.
   function automatic logic ranks_above(elem_type a, elem_type b);
      logic res;
      if (a.profit != b.profit) res = (a.profit > b.profit);
      else res = (a.id < b.id);
      return res;
   endfunction

endpackage

@@ hdl/ipq_ram.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ipq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// -----------------------------------------------------------------------------
module ipq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

@@ hdl/indexed_priority_queue_top.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// indexed_priority_queue_top
// Indexed binary max-heap with an id-to-slot map, held in two RAMs.
// -----------------------------------------------------------------------------
// Each heap level costs one RAM read-modify-write (going down, both children are
// read before the write; going up, the parent), and an insert of a present id
// removes the old entry first. One item is worked on at a time; busy is high
// meanwhile. Reset empties the queue at once; the slot map is checked against
// the heap, so it needs no clearing pass. The result strobe lasts one cycle.
// -----------------------------------------------------------------------------
module indexed_priority_queue_top #(
   parameter int CAPACITY = 1024,
   parameter int ID_SPACE = 32768
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ipq_pkg::req_type req_item,
   output logic             rsp_valid,
   output ipq_pkg::rsp_type rsp_item
);

   localparam int SW = $clog2(CAPACITY + 1);
   localparam int MW = $clog2(ID_SPACE);
   localparam int IW = ipq_pkg::ID_W;

   typedef enum logic [14:0] {
      S_IDLE  = 15'b000000000000001,
      S_MAP   = 15'b000000000000010,
      S_VER   = 15'b000000000000100,
      S_TOP   = 15'b000000000001000,
      S_REM   = 15'b000000000010000,
      S_LAST  = 15'b000000000100000,
      S_DN    = 15'b000000001000000,
      S_DA    = 15'b000000010000000,
      S_DB    = 15'b000000100000000,
      S_DC    = 15'b000001000000000,
      S_UP    = 15'b000010000000000,
      S_UA    = 15'b000100000000000,
      S_PLACE = 15'b001000000000000,
      S_AFTER = 15'b010000000000000,
      S_INS   = 15'b100000000000000
   } state_type;

   state_type          state_ff, state_in;
   ipq_pkg::req_type   req_ff, req_in;
   ipq_pkg::elem_type  cur_ff, cur_in, best_ff, best_in;
   logic [SW-1:0]      h_ff, h_in, cidx_ff, cidx_in, slot_ff, slot_in, count_ff, count_in;
   logic [IW-1:0]      rid_ff, rid_in;
   logic               moved_ff, moved_in, ins_ff, ins_in;
   logic               rsp_valid_ff, rsp_valid_in;
   ipq_pkg::rsp_type   rsp_ff, rsp_in;

   logic               heap_we, heap_re, map_we, map_re;
   logic [SW-1:0]      heap_waddr, heap_raddr;
   ipq_pkg::elem_type  heap_wdata, heap_rdata;
   logic [MW-1:0]      map_waddr, map_raddr;
   logic [SW-1:0]      map_wdata, map_rdata;

   logic [SW:0]        child;
   logic               id_ok;

   assign child = {h_ff, 1'b0};
   assign id_ok = ({2'b00, req_item.item_id} < 17'(ID_SPACE));

   ipq_ram #(.WIDTH(ipq_pkg::ELEM_W), .DEPTH(CAPACITY + 1)) u_heap (
      .clock   (clock),
      .wr_en   (heap_we),
      .wr_addr (heap_waddr),
      .wr_data (heap_wdata),
      .rd_en   (heap_re),
      .rd_addr (heap_raddr),
      .rd_data (heap_rdata)
   );

   ipq_ram #(.WIDTH(SW), .DEPTH(ID_SPACE)) u_map (
      .clock   (clock),
      .wr_en   (map_we),
      .wr_addr (map_waddr),
      .wr_data (map_wdata),
      .rd_en   (map_re),
      .rd_addr (map_raddr),
      .rd_data (map_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cur_in       = cur_ff;
      best_in      = best_ff;
      h_in         = h_ff;
      cidx_in      = cidx_ff;
      slot_in      = slot_ff;
      count_in     = count_ff;
      rid_in       = rid_ff;
      moved_in     = moved_ff;
      ins_in       = ins_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      heap_we      = 1'b0;
      heap_waddr   = h_ff;
      heap_wdata   = cur_ff;
      heap_re      = 1'b0;
      heap_raddr   = h_ff;
      map_we       = 1'b0;
      map_waddr    = MW'(cur_ff.id);
      map_wdata    = h_ff;
      map_re       = 1'b0;
      map_raddr    = MW'(req_item.item_id);

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               rid_in   = '0;
               ins_in   = 1'b0;
               moved_in = 1'b0;
               if (req_item.mode == ipq_pkg::MODE_TAKE) begin
                  if (count_ff == '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = '{status: ipq_pkg::ST_NONE, result_id: '0};
                  end else begin
                     heap_re    = 1'b1;
                     heap_raddr = SW'(1);
                     state_in   = S_TOP;
                  end
               end else if ((req_item.mode == ipq_pkg::MODE_INSERT ||
                             req_item.mode == ipq_pkg::MODE_CANCEL) && id_ok) begin
                  map_re   = 1'b1;
                  state_in = S_MAP;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{status: ipq_pkg::ST_NONE, result_id: '0};
               end
            end
         end
         S_MAP: begin
            slot_in = map_rdata;
            if (map_rdata != '0 && map_rdata <= count_ff) begin
               heap_re    = 1'b1;
               heap_raddr = map_rdata;
               state_in   = S_VER;
            end else if (req_ff.mode == ipq_pkg::MODE_INSERT) begin
               state_in = S_INS;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ipq_pkg::ST_NONE, result_id: '0};
               state_in     = S_IDLE;
            end
         end
         S_VER: begin
            // The map entry may be stale; the id stored in the heap settles it.
            if (heap_rdata.id == req_ff.item_id) begin
               state_in = S_REM;
            end else if (req_ff.mode == ipq_pkg::MODE_INSERT) begin
               state_in = S_INS;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ipq_pkg::ST_NONE, result_id: '0};
               state_in     = S_IDLE;
            end
         end
         S_TOP: begin
            if (heap_rdata.profit < 0) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ipq_pkg::ST_NONE, result_id: '0};
               state_in     = S_IDLE;
            end else begin
               rid_in   = heap_rdata.id;
               slot_in  = SW'(1);
               state_in = S_REM;
            end
         end
         S_REM: begin
            count_in = count_ff - SW'(1);
            if (slot_ff == count_ff) begin
               state_in = S_AFTER;
            end else begin
               heap_re    = 1'b1;
               heap_raddr = count_ff;
               state_in   = S_LAST;
            end
         end
         S_LAST: begin
            cur_in   = heap_rdata;
            h_in     = slot_ff;
            state_in = S_DN;
         end
         S_DN: begin
            if (child > {1'b0, count_ff}) begin
               state_in = moved_ff ? S_PLACE : S_UP;
            end else begin
               heap_re    = 1'b1;
               heap_raddr = child[SW-1:0];
               cidx_in    = child[SW-1:0];
               state_in   = S_DA;
            end
         end
         S_DA: begin
            best_in = heap_rdata;
            if (cidx_ff < count_ff) begin
               heap_re    = 1'b1;
               heap_raddr = cidx_ff + SW'(1);
               state_in   = S_DB;
            end else begin
               state_in = S_DC;
            end
         end
         S_DB: begin
            if (ipq_pkg::ranks_above(heap_rdata, best_ff)) begin
               best_in = heap_rdata;
               cidx_in = cidx_ff + SW'(1);
            end
            state_in = S_DC;
         end
         S_DC: begin
            if (ipq_pkg::ranks_above(best_ff, cur_ff)) begin
               heap_we    = 1'b1;
               heap_wdata = best_ff;
               map_we     = 1'b1;
               map_waddr  = MW'(best_ff.id);
               h_in       = cidx_ff;
               moved_in   = 1'b1;
               state_in   = S_DN;
            end else begin
               state_in = moved_ff ? S_PLACE : S_UP;
            end
         end
         S_UP: begin
            if (h_ff == SW'(1)) begin
               state_in = S_PLACE;
            end else begin
               heap_re    = 1'b1;
               heap_raddr = h_ff >> 1;
               state_in   = S_UA;
            end
         end
         S_UA: begin
            if (ipq_pkg::ranks_above(cur_ff, heap_rdata)) begin
               heap_we    = 1'b1;
               heap_wdata = heap_rdata;
               map_we     = 1'b1;
               map_waddr  = MW'(heap_rdata.id);
               h_in       = h_ff >> 1;
               state_in   = S_UP;
            end else begin
               state_in = S_PLACE;
            end
         end
         S_PLACE: begin
            heap_we  = 1'b1;
            map_we   = 1'b1;
            state_in = S_AFTER;
         end
         S_AFTER: begin
            if (req_ff.mode == ipq_pkg::MODE_INSERT && !ins_ff) begin
               state_in = S_INS;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ipq_pkg::ST_DONE, result_id: rid_ff};
               state_in     = S_IDLE;
            end
         end
         S_INS: begin
            if (count_ff == SW'(CAPACITY)) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{status: ipq_pkg::ST_FULL, result_id: '0};
               state_in     = S_IDLE;
            end else begin
               count_in = count_ff + SW'(1);
               cur_in   = '{id: req_ff.item_id, profit: req_ff.profit};
               h_in     = count_ff + SW'(1);
               ins_in   = 1'b1;
               state_in = S_UP;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         moved_ff     <= 1'b0;
         ins_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         moved_ff     <= moved_in;
         ins_ff       <= ins_in;
      end
      req_ff  <= req_in;
      cur_ff  <= cur_in;
      best_ff <= best_in;
      h_ff    <= h_in;
      cidx_ff <= cidx_in;
      slot_ff <= slot_in;
      rid_ff  <= rid_in;
      rsp_ff  <= rsp_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top
// Testbench of the indexed priority queue. Directed and random operations are
// predicted by a behavioral heap with an id map, and the results are compared.
// -----------------------------------------------------------------------------
module tb_top;

   localparam int CAP    = 1024;
   localparam int IDS    = 32768;
   localparam int TAIL   = 60;

   localparam logic [1:0] MODE_UNUSED = 2'd3;

   // Behavioral heap: larger profit first, equal profits go to the smaller id.
   class heap_scoreboard;
      int unsigned              heap_ids[CAP+1];
      logic signed [31:0]       heap_profits[CAP+1];
      int unsigned              slot_map[IDS];
      int unsigned              count;
      ipq_pkg::rsp_type         pending[$];
      int                       errors;

      function bit outranks(int unsigned a, int unsigned b);
         if (heap_profits[a] != heap_profits[b]) return heap_profits[a] > heap_profits[b];
         return heap_ids[a] < heap_ids[b];
      endfunction

      function void swap_slots(int unsigned a, int unsigned b);
         int unsigned        ti;
         logic signed [31:0] tp;
         ti = heap_ids[a]; tp = heap_profits[a];
         heap_ids[a] = heap_ids[b]; heap_profits[a] = heap_profits[b];
         heap_ids[b] = ti; heap_profits[b] = tp;
         slot_map[heap_ids[a]] = a;
         slot_map[heap_ids[b]] = b;
      endfunction

      function void bubble_up(int unsigned s);
         while (s > 1 && outranks(s, s >> 1)) begin
            swap_slots(s, s >> 1);
            s = s >> 1;
         end
      endfunction

      function void bubble_down(int unsigned s);
         int unsigned c;
         forever begin
            c = s << 1;
            if (c > count) break;
            if (c < count && outranks(c + 1, c)) c++;
            if (!outranks(c, s)) break;
            swap_slots(s, c);
            s = c;
         end
      endfunction

      function int unsigned remove_at(int unsigned s);
         int unsigned gone;
         int unsigned last;
         gone = heap_ids[s];
         last = count;
         count--;
         slot_map[gone] = 0;
         if (s != last) begin
            heap_ids[s] = heap_ids[last];
            heap_profits[s] = heap_profits[last];
            slot_map[heap_ids[s]] = s;
            bubble_down(s);
            bubble_up(s);
         end
         return gone;
      endfunction

      function void note_item(ipq_pkg::req_type r);
         ipq_pkg::rsp_type e;
         int unsigned      s;
         e.status = ipq_pkg::ST_NONE;
         e.result_id = '0;
         s = slot_map[r.item_id];
         if (r.mode == ipq_pkg::MODE_INSERT) begin
            if (s >= 1 && s <= count) void'(remove_at(s));
            if (count >= CAP) e.status = ipq_pkg::ST_FULL;
            else begin
               count++;
               heap_ids[count] = r.item_id;
               heap_profits[count] = r.profit;
               slot_map[r.item_id] = count;
               bubble_up(count);
               e.status = ipq_pkg::ST_DONE;
            end
         end else if (r.mode == ipq_pkg::MODE_CANCEL) begin
            if (s >= 1 && s <= count) begin
               void'(remove_at(s));
               e.status = ipq_pkg::ST_DONE;
            end
         end else if (r.mode == ipq_pkg::MODE_TAKE) begin
            if (count > 0 && heap_profits[1] >= 0) begin
               e.result_id = ipq_pkg::ID_W'(remove_at(1));
               e.status = ipq_pkg::ST_DONE;
            end
         end
         pending.push_back(e);
      endfunction

      function void check_result(ipq_pkg::rsp_type got);
         ipq_pkg::rsp_type e;
         if (pending.size() == 0) begin
            $error("result with no item outstanding: status %0d id %0d",
                   got.status, got.result_id);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (got.status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, got.status);
            errors++;
         end
         if (got.result_id !== e.result_id) begin
            $error("result_id: expected %0d, actual %0d", e.result_id, got.result_id);
            errors++;
         end
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   ipq_pkg::req_type req_item = '0;
   logic             rsp_valid;
   ipq_pkg::rsp_type rsp_item;

   heap_scoreboard sb = new();
   int             idle_pct;
   int unsigned    live_ids[$];

   always #10 clock = ~clock;

   indexed_priority_queue_top i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_item);
   end

   // Offers one item and holds it until the block accepts it. Start stays high
   // afterwards so that the next item can follow at once; idling drops it.
   task automatic send_item(logic [1:0] mode, int unsigned id, logic [31:0] profit);
      ipq_pkg::req_type r;
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      r.mode = mode;
      r.item_id = id[ipq_pkg::ID_W-1:0];
      r.profit = profit;
      req_item <= r;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_item(r);
      if (mode == ipq_pkg::MODE_INSERT && sb.slot_map[r.item_id] != 0)
         live_ids.push_back(r.item_id);
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_profit();
      case ($urandom_range(5))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return $urandom_range(3) - 2;
         3: return $urandom_range(7);
         default: return $urandom;
      endcase
   endfunction

   task automatic random_phase(int n);
      int unsigned id;
      int          k;
      int          sel;
      for (int i = 0; i < n; i++) begin
         sel = $urandom_range(99);
         if (live_ids.size() > 0 && $urandom_range(3) == 0)
            id = live_ids[$urandom_range(live_ids.size() - 1)];
         else if ($urandom_range(1)) id = $urandom_range(63);
         else id = $urandom_range(IDS - 1);
         if (sel < 50) send_item(ipq_pkg::MODE_INSERT, id, pick_profit());
         else if (sel < 68) send_item(ipq_pkg::MODE_CANCEL, id, $urandom);
         else if (sel < 97) send_item(ipq_pkg::MODE_TAKE, $urandom_range(IDS - 1), $urandom);
         else send_item(MODE_UNUSED, id, $urandom);
         k = live_ids.size();
         if (k > 200) live_ids.delete(0);
      end
   endtask

   initial begin
      idle_pct = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty queue, extremes, ties, duplicate, negative best, bad mode.
      send_item(ipq_pkg::MODE_TAKE, 0, 0);
      send_item(ipq_pkg::MODE_CANCEL, 5, 0);
      send_item(ipq_pkg::MODE_INSERT, 0, 32'h7fff_ffff);
      send_item(ipq_pkg::MODE_INSERT, 32767, 32'h8000_0000);
      send_item(ipq_pkg::MODE_INSERT, 7, 32'd5);
      send_item(ipq_pkg::MODE_INSERT, 3, 32'd5);
      send_item(ipq_pkg::MODE_INSERT, 3, 32'd9);
      send_item(ipq_pkg::MODE_INSERT, 21845, 32'h5555_5555);
      send_item(ipq_pkg::MODE_INSERT, 10922, 32'haaaa_aaaa);
      send_item(MODE_UNUSED, 7, 0);
      send_item(ipq_pkg::MODE_CANCEL, 7, 0);
      send_item(ipq_pkg::MODE_CANCEL, 7, 0);
      for (int i = 0; i < 5; i++) send_item(ipq_pkg::MODE_TAKE, 0, 0);
      send_item(ipq_pkg::MODE_CANCEL, 32767, 0);
      send_item(ipq_pkg::MODE_TAKE, 0, 0);
      drain_results();

      // Fill to capacity under the three idling patterns, then overflow.
      idle_pct = 28;
      for (int i = 0; i < CAP; i++) begin
         if (i == CAP / 3) idle_pct = 78;
         else if (i == 2 * CAP / 3) idle_pct = 0;
         send_item(ipq_pkg::MODE_INSERT, 100 + i, $urandom);
      end
      send_item(ipq_pkg::MODE_INSERT, 9000, 0);
      send_item(ipq_pkg::MODE_INSERT, 100, 32'd1);
      send_item(ipq_pkg::MODE_CANCEL, 500, 0);
      drain_results();

      // Mixed operations on the nearly full heap.
      random_phase(24);
      drain_results();
      repeat (TAIL) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end
endmodule
